@@ rtl/cbs_pkg.sv @@
package cbs_pkg;

	// Largest face edge the datapath handles; larger settings are clamped to it.
	localparam int unsigned MAX_FACE_SIZE = 4096;
	localparam int unsigned FACE_W        = 3;
	localparam int unsigned SRC_W         = 12;
	localparam int unsigned COORD_W       = 13;
	localparam int unsigned SAMPLE_W      = 32;
	localparam int unsigned NUM_PAIRS     = 12;
	localparam int unsigned NUM_CAND      = 2 * NUM_PAIRS;
	localparam int unsigned CAND_W        = $clog2(NUM_CAND);
	localparam int unsigned MAX_RESULTS   = 3;
	localparam int unsigned RES_IDX_W     = $clog2(MAX_RESULTS);
	localparam int unsigned RES_CNT_W     = $clog2(MAX_RESULTS + 1);
	localparam logic [FACE_W-1:0]  LAST_FACE     = FACE_W'(5);
	localparam logic [COORD_W-1:0] FACE_SIZE_RST = COORD_W'(256);
	localparam logic [COORD_W-1:0] FACE_SIZE_MAX = COORD_W'(MAX_FACE_SIZE);

	// Orientation of a face edge relative to its neighbor.
	typedef enum logic [1:0] {
		ROT_N = 2'd0,
		ROT_L = 2'd1,
		ROT_R = 2'd2
	} rot_t;

	typedef struct packed {
		logic [FACE_W-1:0] fa;
		rot_t              ra;
		logic [FACE_W-1:0] fb;
		rot_t              rb;
	} pair_t;

	// Face adjacency, in the order the border copies are issued.
	localparam pair_t PAIR_TABLE [NUM_PAIRS] = '{
		'{3'd0, ROT_N, 3'd5, ROT_N}, '{3'd5, ROT_N, 3'd1, ROT_N},
		'{3'd1, ROT_N, 3'd4, ROT_N}, '{3'd4, ROT_N, 3'd0, ROT_N},
		'{3'd1, ROT_R, 3'd2, ROT_N}, '{3'd1, ROT_L, 3'd3, ROT_N},
		'{3'd2, ROT_N, 3'd0, ROT_L}, '{3'd3, ROT_N, 3'd0, ROT_R},
		'{3'd2, ROT_L, 3'd4, ROT_L}, '{3'd2, ROT_R, 3'd5, ROT_L},
		'{3'd3, ROT_L, 3'd5, ROT_R}, '{3'd3, ROT_R, 3'd4, ROT_R}
	};

	typedef struct packed {
		logic [FACE_W-1:0]   face;
		logic [SRC_W-1:0]    row;
		logic [SRC_W-1:0]    col;
		logic [SAMPLE_W-1:0] sample;
	} pixel_t;

	typedef struct packed {
		logic [COORD_W-1:0] a;
		logic [COORD_W-1:0] b;
	} coord_t;

	typedef struct packed {
		logic [FACE_W-1:0]  face;
		logic [COORD_W-1:0] row;
		logic [COORD_W-1:0] col;
	} dest_t;

	// Padded (row, col) to edge coordinates (i, j); n1 is the face size plus one.
	function automatic coord_t rot_inv(rot_t rot, logic [COORD_W-1:0] n1,
			logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
		coord_t ij;
		case (rot)
			ROT_L: begin
				ij.a = n1 - col;
				ij.b = row;
			end
			ROT_R: begin
				ij.a = col;
				ij.b = n1 - row;
			end
			default: begin
				ij.a = row;
				ij.b = col;
			end
		endcase
		return ij;
	endfunction

	// Edge coordinates (i, j) to padded (row, col).
	function automatic coord_t rot_fwd(rot_t rot, logic [COORD_W-1:0] n1,
			logic [COORD_W-1:0] i, logic [COORD_W-1:0] j);
		coord_t rc;
		case (rot)
			ROT_L: begin
				rc.a = j;
				rc.b = n1 - i;
			end
			ROT_R: begin
				rc.a = n1 - j;
				rc.b = i;
			end
			default: begin
				rc.a = i;
				rc.b = j;
			end
		endcase
		return rc;
	endfunction

	// Position of the lowest set bit; zero when none is set.
	function automatic logic [CAND_W-1:0] lowest_bit(logic [NUM_CAND-1:0] v);
		logic [CAND_W-1:0] idx;
		idx = '0;
		for (int k = NUM_CAND - 1; k >= 0; k--) begin
			if (v[k]) begin
				idx = CAND_W'(k);
			end
		end
		return idx;
	endfunction

endpackage

@@ rtl/cbs_if.sv @@
interface cbs_pixel_if import cbs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FACE_W-1:0]   face_index;
	logic [SRC_W-1:0]    src_row;
	logic [SRC_W-1:0]    src_col;
	logic [SAMPLE_W-1:0] sample_value;

	modport source(output valid, face_index, src_row, src_col, sample_value, input ready);
	modport sink(input valid, face_index, src_row, src_col, sample_value, output ready);
endinterface

interface cbs_copy_if import cbs_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [FACE_W-1:0]   dest_face;
	logic [COORD_W-1:0]  dest_row;
	logic [COORD_W-1:0]  dest_col;
	logic [SAMPLE_W-1:0] sample_out;
	logic                last_copy;

	modport source(output valid, dest_face, dest_row, dest_col, sample_out, last_copy,
		input ready);
	modport sink(input valid, dest_face, dest_row, dest_col, sample_out, last_copy,
		output ready);
endinterface

@@ rtl/cubemap_border_scatter.sv @@
// Channel      Direction  Carries
// src_pixel    sink       face_index, src_row, src_col, sample_value
// dest_copy    source     dest_face, dest_row, dest_col, sample_out, last_copy
// face_size_*  write      face edge length, clamped to 4096 when stored
//
// One input register feeds the border logic, whose copies land in one output
// register. An interior pixel produces one copy, an edge pixel two or three;
// a rejected pixel produces none. The output register issues one copy per
// cycle; the input stalls while an edge pixel issues its extra copies or
// while the output is held.
// Reset clears all valid flags and sets the face size to 256.
module cubemap_border_scatter import cbs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               face_size_we,
	input  logic [COORD_W-1:0] face_size_wdata,
	cbs_pixel_if.sink          src_pixel,
	cbs_copy_if.source         dest_copy
);

	logic [COORD_W-1:0]    n_q;
	logic                  valid_s1;
	pixel_t                pix_s1;
	dest_t                 dest [MAX_RESULTS];
	logic [RES_CNT_W-1:0]  count;
	logic [RES_IDX_W-1:0]  idx_q;
	logic                  out_valid_q;
	dest_t                 out_dest_q;
	logic [SAMPLE_W-1:0]   out_sample_q;
	logic                  out_last_q;
	logic                  out_free;
	logic                  emit;
	logic                  is_last;
	logic                  consume;
	logic                  in_ready;

	// Face size register, clamped to the supported maximum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q <= FACE_SIZE_RST;
		end else if (face_size_we) begin
			n_q <= (face_size_wdata > FACE_SIZE_MAX) ? FACE_SIZE_MAX : face_size_wdata;
		end
	end

	cbs_border_calc u_calc (
		.pix       (pix_s1),
		.face_size (n_q),
		.dest      (dest),
		.count     (count)
	);

	// Copy sequencing: one copy per cycle into the output register while it is free.
	assign out_free = !out_valid_q || dest_copy.ready;
	assign is_last  = (RES_CNT_W'(idx_q) == (count - RES_CNT_W'(1)));
	assign emit     = valid_s1 && (count != '0) && out_free;
	assign consume  = valid_s1 && ((count == '0) || (out_free && is_last));
	assign in_ready = !valid_s1 || consume;

	assign src_pixel.ready = in_ready;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= src_pixel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && src_pixel.valid) begin
			pix_s1 <= '{face: src_pixel.face_index, row: src_pixel.src_row,
				col: src_pixel.src_col, sample: src_pixel.sample_value};
		end
	end

	// Copy index within the current pixel.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
		end else if (emit) begin
			idx_q <= is_last ? '0 : idx_q + RES_IDX_W'(1);
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_dest_q   <= dest[idx_q];
			out_sample_q <= pix_s1.sample;
			out_last_q   <= is_last;
		end
	end

	assign dest_copy.valid      = out_valid_q;
	assign dest_copy.dest_face  = out_dest_q.face;
	assign dest_copy.dest_row   = out_dest_q.row;
	assign dest_copy.dest_col   = out_dest_q.col;
	assign dest_copy.sample_out = out_sample_q;
	assign dest_copy.last_copy  = out_last_q;

endmodule

@@ rtl/cbs_border_calc.sv @@
module cbs_border_calc import cbs_pkg::*; (
	input  pixel_t                 pix,
	input  logic [COORD_W-1:0]     face_size,
	output dest_t                  dest [MAX_RESULTS],
	output logic [RES_CNT_W-1:0]   count
);

	logic                 pos_ok;
	logic [COORD_W-1:0]   r;
	logic [COORD_W-1:0]   c;
	logic [COORD_W-1:0]   n1;
	logic [NUM_CAND-1:0]  hit;
	dest_t                cand [NUM_CAND];
	coord_t               inv_a [NUM_PAIRS];
	coord_t               inv_b [NUM_PAIRS];
	coord_t               fwd_a [NUM_PAIRS];
	coord_t               fwd_b [NUM_PAIRS];
	logic [CAND_W-1:0]    first_idx;
	logic [CAND_W-1:0]    second_idx;
	logic [NUM_CAND-1:0]  rest;
	logic                 has_one;
	logic                 has_two;

	// Reject bad faces, a zero face size and positions outside the face.
	assign pos_ok = (pix.face <= LAST_FACE) && (face_size != '0)
		&& ({1'b0, pix.row} < face_size) && ({1'b0, pix.col} < face_size);

	assign r  = {1'b0, pix.row} + COORD_W'(1);
	assign c  = {1'b0, pix.col} + COORD_W'(1);
	assign n1 = face_size + COORD_W'(1);

	// Every pair checks both of its sides in parallel.
	always_comb begin
		for (int p = 0; p < NUM_PAIRS; p++) begin
			inv_a[p] = rot_inv(PAIR_TABLE[p].ra, n1, r, c);
			fwd_a[p] = rot_fwd(PAIR_TABLE[p].rb, n1, inv_a[p].a, '0);
			hit[2*p] = pos_ok && (pix.face == PAIR_TABLE[p].fa) && (inv_a[p].b == face_size);
			cand[2*p] = '{face: PAIR_TABLE[p].fb, row: fwd_a[p].a, col: fwd_a[p].b};

			inv_b[p] = rot_inv(PAIR_TABLE[p].rb, n1, r, c);
			fwd_b[p] = rot_fwd(PAIR_TABLE[p].ra, n1, inv_b[p].a, n1);
			hit[2*p+1] = pos_ok && (pix.face == PAIR_TABLE[p].fb)
				&& (inv_b[p].b == COORD_W'(1));
			cand[2*p+1] = '{face: PAIR_TABLE[p].fa, row: fwd_b[p].a, col: fwd_b[p].b};
		end
	end

	// Keep the first two border copies in table order.
	assign first_idx  = lowest_bit(hit);
	assign rest       = hit & ~(NUM_CAND'(1) << first_idx);
	assign second_idx = lowest_bit(rest);
	assign has_one    = |hit;
	assign has_two    = |rest;

	assign dest[0] = '{face: pix.face, row: r, col: c};
	assign dest[1] = cand[first_idx];
	assign dest[2] = cand[second_idx];

	assign count = pos_ok ? (RES_CNT_W'(1) + RES_CNT_W'(has_one) + RES_CNT_W'(has_two))
		: '0;

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import cbs_pkg::*;

	localparam int unsigned CYCLE_LIMIT  = 200000;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned PHASE_PIXELS = 10;
	localparam int unsigned IDLE_PIXELS  = 8;
	localparam int unsigned NUM_PHASES   = 9;
	localparam int unsigned HOLD_AFTER   = 60;
	localparam int unsigned HOLD_CYCLES  = 100;

	// One copy of a pixel as it should leave the block.
	typedef struct packed {
		logic [FACE_W-1:0]   face;
		logic [COORD_W-1:0]  row;
		logic [COORD_W-1:0]  col;
		logic [SAMPLE_W-1:0] sample;
		logic                last;
	} copy_t;

	// Shared edge between two faces and how each side is oriented.
	typedef struct packed {
		logic [FACE_W-1:0] fa;
		rot_t              ra;
		logic [FACE_W-1:0] fb;
		rot_t              rb;
	} adjacency_t;

	localparam adjacency_t FACE_ADJ [NUM_PAIRS] = '{
		'{3'd0, ROT_N, 3'd5, ROT_N}, '{3'd5, ROT_N, 3'd1, ROT_N},
		'{3'd1, ROT_N, 3'd4, ROT_N}, '{3'd4, ROT_N, 3'd0, ROT_N},
		'{3'd1, ROT_R, 3'd2, ROT_N}, '{3'd1, ROT_L, 3'd3, ROT_N},
		'{3'd2, ROT_N, 3'd0, ROT_L}, '{3'd3, ROT_N, 3'd0, ROT_R},
		'{3'd2, ROT_L, 3'd4, ROT_L}, '{3'd2, ROT_R, 3'd5, ROT_L},
		'{3'd3, ROT_L, 3'd5, ROT_R}, '{3'd3, ROT_R, 3'd4, ROT_R}
	};

	// Directed pixel; when fixed is set, the outcome is typed in: either a
	// single interior copy or nothing at all.
	typedef struct packed {
		logic [FACE_W-1:0]   face;
		logic [SRC_W-1:0]    row;
		logic [SRC_W-1:0]    col;
		logic [SAMPLE_W-1:0] sample;
		logic                fixed;
		logic                interior;
	} directed_pixel_t;

	// Directed pixels, all sent with the face size left at its reset value of 256.
	localparam int unsigned NUM_DIRECTED = 22;
	localparam directed_pixel_t DIRECTED_PIXELS [NUM_DIRECTED] = '{
		'{3'd0, 12'd10,   12'd20,   32'h1234_5678, 1'b1, 1'b1},
		'{3'd5, 12'd100,  12'd200,  32'hFFFF_FFFF, 1'b1, 1'b1},
		'{3'd3, 12'd128,  12'd128,  32'h0000_0000, 1'b1, 1'b1},
		'{3'd6, 12'd0,    12'd0,    32'hA5A5_A5A5, 1'b1, 1'b0},
		'{3'd7, 12'd4095, 12'd4095, 32'h5A5A_5A5A, 1'b1, 1'b0},
		'{3'd0, 12'd256,  12'd0,    32'h0000_0001, 1'b1, 1'b0},
		'{3'd2, 12'd0,    12'd256,  32'h8000_0000, 1'b1, 1'b0},
		'{3'd4, 12'd4095, 12'd4095, 32'hDEAD_BEEF, 1'b1, 1'b0},
		'{3'd0, 12'd0,    12'd0,    32'h0000_0000, 1'b0, 1'b0},
		'{3'd0, 12'd255,  12'd255,  32'hFFFF_FFFF, 1'b0, 1'b0},
		'{3'd1, 12'd0,    12'd128,  32'h1111_1111, 1'b0, 1'b0},
		'{3'd1, 12'd128,  12'd0,    32'h2222_2222, 1'b0, 1'b0},
		'{3'd1, 12'd128,  12'd255,  32'h3333_3333, 1'b0, 1'b0},
		'{3'd2, 12'd255,  12'd0,    32'h4444_4444, 1'b0, 1'b0},
		'{3'd3, 12'd0,    12'd255,  32'h5555_5555, 1'b0, 1'b0},
		'{3'd4, 12'd255,  12'd128,  32'h6666_6666, 1'b0, 1'b0},
		'{3'd5, 12'd128,  12'd255,  32'h7777_7777, 1'b0, 1'b0},
		'{3'd2, 12'd0,    12'd0,    32'h8888_8888, 1'b0, 1'b0},
		'{3'd4, 12'd0,    12'd0,    32'h9999_9999, 1'b0, 1'b0},
		'{3'd5, 12'd255,  12'd255,  32'hAAAA_AAAA, 1'b0, 1'b0},
		'{3'd3, 12'd255,  12'd0,    32'hBBBB_BBBB, 1'b0, 1'b0},
		'{3'd0, 12'd128,  12'd0,    32'hCCCC_CCCC, 1'b0, 1'b0}
	};

	// Face sizes for the random phases; the last one is drawn at run time.
	localparam int unsigned PHASE_SIZES [NUM_PHASES] = '{
		1, 2, 3, 4096, 0, 8191, 5, 4095, 0
	};

	logic clk;
	logic arst_n;
	logic face_size_we;
	logic [COORD_W-1:0] face_size_wdata;

	cbs_pixel_if pix ();
	cbs_copy_if cpy ();

	cubemap_border_scatter i_dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.face_size_we    (face_size_we),
		.face_size_wdata (face_size_wdata),
		.src_pixel       (pix),
		.dest_copy       (cpy)
	);

	copy_t pending_copies [$];
	logic [COORD_W-1:0] face_size_q;
	int unsigned cycle_count = 0;
	int unsigned copies_seen = 0;
	int unsigned pixels_sent;
	int unsigned pixels_scattered;
	int unsigned sizes_used;
	int unsigned err_count = 0;
	int unsigned rx_wait = 0;
	bit rx_burst = 1'b0;
	bit tx_burst;
	logic hold_rx;

	// Clock.
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog on the total run length.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH at copy %0d, %s: got %0h, expected %0h",
			copies_seen, what, got, want);
		err_count++;
	endtask

	// Adds one copy at the tail of the expected list.
	function automatic void queue_copy(input copy_t c);
		pending_copies.insert(pending_copies.size(), c);
	endfunction

	function automatic copy_t mk_copy(input int unsigned face, input int unsigned row,
			input int unsigned col, input logic [SAMPLE_W-1:0] sample);
		copy_t c;
		c.face   = FACE_W'(face);
		c.row    = COORD_W'(row);
		c.col    = COORD_W'(col);
		c.sample = sample;
		c.last   = 1'b0;
		return c;
	endfunction

	// Padded (row, col) to edge coordinates (i, j).
	function automatic void to_edge(input rot_t rot, input int unsigned n,
			input int unsigned row, input int unsigned col,
			output int unsigned i, output int unsigned j);
		case (rot)
			ROT_L: begin
				i = n + 1 - col;
				j = row;
			end
			ROT_R: begin
				i = col;
				j = n + 1 - row;
			end
			default: begin
				i = row;
				j = col;
			end
		endcase
	endfunction

	// Edge coordinates (i, j) to padded (row, col).
	function automatic void to_padded(input rot_t rot, input int unsigned n,
			input int unsigned i, input int unsigned j,
			output int unsigned row, output int unsigned col);
		case (rot)
			ROT_L: begin
				row = j;
				col = n + 1 - i;
			end
			ROT_R: begin
				row = n + 1 - j;
				col = i;
			end
			default: begin
				row = i;
				col = j;
			end
		endcase
	endfunction

	// Appends the copies a pixel scatters to under the current face size and
	// returns how many there are.
	function automatic int predict_scatter(input logic [FACE_W-1:0] face,
			input logic [SRC_W-1:0] row, input logic [SRC_W-1:0] col,
			input logic [SAMPLE_W-1:0] sample);
		int unsigned n, r, c, i, j, dr, dc;
		int k;
		n = (face_size_q > MAX_FACE_SIZE) ? MAX_FACE_SIZE : face_size_q;
		if (face > LAST_FACE || n == 0 || row >= n || col >= n) begin
			return 0;
		end
		r = row + 1;
		c = col + 1;
		queue_copy(mk_copy(face, r, c, sample));
		k = 1;
		for (int p = 0; p < NUM_PAIRS; p++) begin
			// Face-a side: this pixel sits on the edge that borders face b.
			if (k < MAX_RESULTS && face == FACE_ADJ[p].fa) begin
				to_edge(FACE_ADJ[p].ra, n, r, c, i, j);
				if (j == n) begin
					to_padded(FACE_ADJ[p].rb, n, i, 0, dr, dc);
					queue_copy(mk_copy(FACE_ADJ[p].fb, dr, dc, sample));
					k++;
				end
			end
			// Face-b side: this pixel sits on the edge that borders face a.
			if (k < MAX_RESULTS && face == FACE_ADJ[p].fb) begin
				to_edge(FACE_ADJ[p].rb, n, r, c, i, j);
				if (j == 1) begin
					to_padded(FACE_ADJ[p].ra, n, i, n + 1, dr, dc);
					queue_copy(mk_copy(FACE_ADJ[p].fa, dr, dc, sample));
					k++;
				end
			end
		end
		pending_copies[$].last = 1'b1;
		return k;
	endfunction

	// Offers one pixel after a random gap and waits for its transaction.
	task automatic send_pixel(input logic [FACE_W-1:0] face, input logic [SRC_W-1:0] row,
			input logic [SRC_W-1:0] col, input logic [SAMPLE_W-1:0] sample,
			input bit fixed, input bit interior, output int num_copies);
		int unsigned gap;
		copy_t fixed_copy;
		if ($urandom_range(0, 11) == 0) begin
			tx_burst = !tx_burst;
		end
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			pix.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix.valid        <= 1'b1;
		pix.face_index   <= face;
		pix.src_row      <= row;
		pix.src_col      <= col;
		pix.sample_value <= sample;
		do @(posedge clk); while (!pix.ready);
		pixels_sent++;
		if (fixed) begin
			num_copies = interior ? 1 : 0;
			if (interior) begin
				fixed_copy = mk_copy(face, row + 1, col + 1, sample);
				fixed_copy.last = 1'b1;
				queue_copy(fixed_copy);
			end
		end else begin
			num_copies = predict_scatter(face, row, col, sample);
		end
		if (num_copies != 0) begin
			pixels_scattered++;
		end
	endtask

	// Stops offering and waits for every expected copy, then for the extra cycles
	// given, for a rejected pixel that may still be in flight.
	task automatic drain(input int unsigned extra);
		pix.valid <= 1'b0;
		do @(posedge clk); while (pending_copies.size() != 0);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_face_size(input logic [COORD_W-1:0] value);
		face_size_we    <= 1'b1;
		face_size_wdata <= value;
		@(posedge clk);
		face_size_we <= 1'b0;
		face_size_q = value;
		sizes_used++;
	endtask

	// Receiver: checks each copy transaction and draws its next wait.
	always @(posedge clk) begin : rx_side
		logic rdy;
		copy_t want;
		if (!arst_n) begin
			cpy.ready <= 1'b0;
		end else begin
			if (cpy.valid && cpy.ready) begin
				if (pending_copies.size() == 0) begin
					report_mismatch("unexpected copy to face", 32'(cpy.dest_face), 32'd0);
				end else begin
					want = pending_copies.pop_front();
					if (cpy.dest_face !== want.face) begin
						report_mismatch("dest_face", 32'(cpy.dest_face), 32'(want.face));
					end
					if (cpy.dest_row !== want.row) begin
						report_mismatch("dest_row", 32'(cpy.dest_row), 32'(want.row));
					end
					if (cpy.dest_col !== want.col) begin
						report_mismatch("dest_col", 32'(cpy.dest_col), 32'(want.col));
					end
					if (cpy.sample_out !== want.sample) begin
						report_mismatch("sample_out", cpy.sample_out, want.sample);
					end
					if (cpy.last_copy !== want.last) begin
						report_mismatch("last_copy", 32'(cpy.last_copy), 32'(want.last));
					end
				end
				copies_seen++;
				if ($urandom_range(0, 15) == 0) begin
					rx_burst = !rx_burst;
				end
				rx_wait = rx_burst ? 0 : $urandom_range(0, 9);
			end
			if (hold_rx || rx_wait != 0) begin
				rdy = 1'b0;
				if (!hold_rx) begin
					rx_wait--;
				end
			end else begin
				rdy = 1'b1;
			end
			cpy.ready <= rdy;
		end
	end

	// Long receiver hold-off so the block backs up into its input.
	initial begin
		hold_rx = 1'b0;
		wait (copies_seen >= HOLD_AFTER);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_rx <= 1'b0;
	end

	// Stimulus and end of run.
	initial begin
		int num_copies;
		int unsigned fs, nn, made, sent, pick;
		logic [FACE_W-1:0] face;
		logic [SRC_W-1:0] row, col;
		arst_n           = 1'b0;
		face_size_we     = 1'b0;
		face_size_wdata  = '0;
		pix.valid        = 1'b0;
		pix.face_index   = '0;
		pix.src_row      = '0;
		pix.src_col      = '0;
		pix.sample_value = '0;
		face_size_q      = FACE_SIZE_RST;
		pixels_sent      = 0;
		pixels_scattered = 0;
		sizes_used       = 0;
		tx_burst         = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed pixels at the reset face size.
		for (int d = 0; d < NUM_DIRECTED; d++) begin
			send_pixel(DIRECTED_PIXELS[d].face, DIRECTED_PIXELS[d].row,
				DIRECTED_PIXELS[d].col, DIRECTED_PIXELS[d].sample,
				DIRECTED_PIXELS[d].fixed, DIRECTED_PIXELS[d].interior, num_copies);
		end
		drain(DRAIN_CYCLES);

		// Random phases, one face size each; mostly edge and in-face pixels.
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			fs = (ph == NUM_PHASES - 1) ? $urandom_range(6, 300) : PHASE_SIZES[ph];
			write_face_size(COORD_W'(fs));
			nn = (fs > MAX_FACE_SIZE) ? MAX_FACE_SIZE : fs;
			made = 0;
			sent = 0;
			while ((nn != 0 && made < PHASE_PIXELS) || (nn == 0 && sent < IDLE_PIXELS)) begin
				pick = $urandom_range(0, 99);
				face = FACE_W'($urandom_range(0, 5));
				if (nn == 0 || pick < 10) begin
					face = FACE_W'($urandom_range(0, 7));
					row  = SRC_W'($urandom);
					col  = SRC_W'($urandom);
				end else if (pick < 18) begin
					// Position outside the face; with the largest face only an
					// invalid face index can be rejected.
					row = SRC_W'($urandom);
					col = SRC_W'($urandom);
					if (nn < MAX_FACE_SIZE) begin
						if (pick < 14) begin
							row = SRC_W'($urandom_range(nn, 4095));
						end else begin
							col = SRC_W'($urandom_range(nn, 4095));
						end
					end else begin
						face = FACE_W'($urandom_range(6, 7));
					end
				end else begin
					row = SRC_W'($urandom_range(0, nn - 1));
					col = SRC_W'($urandom_range(0, nn - 1));
					// Put most of these on one of the four face edges.
					if (pick < 60) begin
						case ($urandom_range(0, 3))
							0: row = '0;
							1: row = SRC_W'(nn - 1);
							2: col = '0;
							default: col = SRC_W'(nn - 1);
						endcase
					end
				end
				send_pixel(face, row, col, $urandom, 1'b0, 1'b0, num_copies);
				sent++;
				if (num_copies != 0) begin
					made++;
				end
				// Once, the sender stops mid-phase until every copy is out.
				if (ph == 2 && sent == 7) begin
					drain(0);
				end
			end
			drain(DRAIN_CYCLES);
		end

		$display("Sent %0d pixels, %0d of them scattered, and checked %0d copies",
			pixels_sent, pixels_scattered, copies_seen);
		$display("over %0d face-size writes after the reset size, from 0 and 1 up to 8191.",
			sizes_used);
		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
